[hw/rtl/fdr_pkg.sv]
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants
// widths and cell payload structs for the fresnel reflectance pipeline
// ----------------------------------------------------------------------------
package fdr_pkg;

    localparam int ETA_W    = 16;
    localparam int COS_W    = 16;
    localparam int C_W      = 15;   // |cos| up to 16384
    localparam int SQ_W     = 32;   // squared index
    localparam int S2_W     = 29;   // sin^2 in Q1.28
    localparam int LHS_W    = 61;
    localparam int D_W      = 60;
    localparam int ROOT_W   = 30;
    localparam int REM_W    = 32;
    localparam int PROD_W   = 47;   // nt*nt*c and ni*nt*c
    localparam int RB_W     = 46;   // index times root
    localparam int DEN_W    = 48;
    localparam int DREM_W   = 49;
    localparam int QUO_W    = 17;
    localparam int REFL_W   = 16;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic [ETA_W-1:0]  ETA_ONE   = 16'd8192;
    localparam logic [REFL_W-1:0] REFL_FULL = 16'd32768;

    localparam logic [0:0] REG_ETA_I = 1'b0;
    localparam logic [0:0] REG_ETA_T = 1'b1;

    // data that rides along the square root cells
    typedef struct packed {
        logic              tir;
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] cc;
        logic [ETA_W-1:0]  ni;
        logic [ETA_W-1:0]  nt;
    } t_side;

    typedef struct packed {
        logic [D_W-1:0]    d;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } t_lane;

    typedef struct packed {
        logic  tir;
        t_lane p;
        t_lane q;
    } t_div;

endpackage

[hw/rtl/fdr_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// fdr_sqrt_cell: one root bit
// restoring square root step, two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
module fdr_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fdr_pkg::t_side      i_side,
    input  fdr_pkg::t_sq        i_sq,
    output logic                o_valid,
    output fdr_pkg::t_side      o_side,
    output fdr_pkg::t_sq        o_sq
);

    logic [fdr_pkg::REM_W+1:0] w_tmp;
    logic [fdr_pkg::REM_W+1:0] w_trial;
    logic                      w_ge;
    fdr_pkg::t_sq              n_sq;

    always_comb begin
        w_tmp   = {i_sq.rem, i_sq.d[fdr_pkg::D_W-1 -: 2]};
        w_trial = {2'b00, i_sq.root, 2'b01};
        w_ge    = (w_tmp >= w_trial);
        n_sq.d  = {i_sq.d[fdr_pkg::D_W-3:0], 2'b00};
        if (w_ge) begin
            n_sq.rem  = fdr_pkg::REM_W'(w_tmp - w_trial);
            n_sq.root = {i_sq.root[fdr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_sq.rem  = fdr_pkg::REM_W'(w_tmp);
            n_sq.root = {i_sq.root[fdr_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side <= i_side;
        o_sq   <= n_sq;
    end

endmodule

[hw/rtl/fdr_div_cell.sv]
// ----------------------------------------------------------------------------
// fdr_div_cell: one quotient bit for both ratios
// restoring division step on the parallel and perpendicular lanes
// ----------------------------------------------------------------------------
module fdr_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  fdr_pkg::t_div  i_div,
    output logic           o_valid,
    output fdr_pkg::t_div  o_div
);

    function automatic fdr_pkg::t_lane lane_step(input fdr_pkg::t_lane l);
        fdr_pkg::t_lane              n;
        logic                        ge;
        logic [fdr_pkg::DREM_W-1:0]  r2;
        ge    = (l.rem >= {1'b0, l.den});
        r2    = ge ? (l.rem - {1'b0, l.den}) : l.rem;
        n.rem = {r2[fdr_pkg::DREM_W-2:0], 1'b0};
        n.den = l.den;
        n.quo = {l.quo[fdr_pkg::QUO_W-2:0], ge};
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_div.tir <= i_div.tir;
        o_div.p   <= lane_step(i_div.p);
        o_div.q   <= lane_step(i_div.q);
    end

endmodule

[hw/rtl/fresnel_dielectric_reflectance.sv]
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance: unpolarized dielectric fresnel term
// fixed point pipeline: snell test, bit-serial square root chain, one
// division chain with two lanes for the amplitude ratios, mean of squares with rounding
// ----------------------------------------------------------------------------
// channel   direction  signals                               handshake
// command   in         i_cos_incident                        start / busy
// result    out        o_reflectance, o_total_reflection     o_valid strobe
// config    in         i_cfg_idx, i_cfg_data                 i_cfg_we
//
// one item accepted per cycle, busy is never raised
// result strobes once the item has passed 4 front stages, 30 square root
// cells, 2 stages for products and ratios, 17 divider cells and 2 output
// stages; the cell chains set the latency
// synchronous active low reset clears valid flags and loads both indices
// with 1.0; the receiver cannot stall, results are never held
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [fdr_pkg::COS_W-1:0] i_cos_incident,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [fdr_pkg::ETA_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    output logic [fdr_pkg::REFL_W-1:0]     o_reflectance,
    output logic                           o_total_reflection
);

    // configuration
    logic [fdr_pkg::ETA_W-1:0] r_eta_i;
    logic [fdr_pkg::ETA_W-1:0] r_eta_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_i <= fdr_pkg::ETA_ONE;
            r_eta_t <= fdr_pkg::ETA_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fdr_pkg::REG_ETA_I: r_eta_i <= i_cfg_data;
                fdr_pkg::REG_ETA_T: r_eta_t <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic w_acc;
    assign w_acc = start && !busy;

    // stage 0: clamp, fold sign into an index swap, zero index reads as one LSB
    logic                           r_v0;
    logic [fdr_pkg::C_W-1:0]        r_c0;
    logic [fdr_pkg::ETA_W-1:0]      r_ni0, r_nt0;
    logic [fdr_pkg::C_W-1:0]        n_c0;
    logic [fdr_pkg::ETA_W-1:0]      n_ni0, n_nt0, w_ni, w_nt;

    always_comb begin
        w_ni = (r_eta_i == '0) ? fdr_pkg::ETA_W'(1) : r_eta_i;
        w_nt = (r_eta_t == '0) ? fdr_pkg::ETA_W'(1) : r_eta_t;
        if (i_cos_incident > 16'sd16384) begin
            n_c0 = 15'd16384;
        end else if (i_cos_incident >= 16'sd0) begin
            n_c0 = fdr_pkg::C_W'(i_cos_incident);
        end else if (i_cos_incident < -16'sd16384) begin
            n_c0 = 15'd16384;
        end else begin
            n_c0 = fdr_pkg::C_W'(-i_cos_incident);
        end
        if (i_cos_incident < 16'sd0) begin
            n_ni0 = w_nt;
            n_nt0 = w_ni;
        end else begin
            n_ni0 = w_ni;
            n_nt0 = w_nt;
        end
    end

    // stage 1: squares and product of the indices, sin^2 from the squared cosine
    logic                          r_v1;
    logic [fdr_pkg::C_W-1:0]       r_c1;
    logic [fdr_pkg::ETA_W-1:0]     r_ni1, r_nt1;
    logic [fdr_pkg::SQ_W-1:0]      r_ni2, r_nt2, r_nint;
    logic [fdr_pkg::S2_W-1:0]      r_s2;
    logic [2*fdr_pkg::C_W-1:0]     w_cc;

    assign w_cc = r_c0 * r_c0;

    // stage 2: snell products and ratio numerators
    logic                          r_v2;
    logic [fdr_pkg::ETA_W-1:0]     r_ni2x, r_nt2x;
    logic [fdr_pkg::LHS_W-1:0]     r_lhs;
    logic [fdr_pkg::D_W-1:0]       r_rhs;
    logic [fdr_pkg::PROD_W-1:0]    r_a2, r_cc2;

    // stage 3: total reflection test and radicand
    logic                          r_v3;
    fdr_pkg::t_side                r_side3;
    fdr_pkg::t_sq                  r_sq3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_acc;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0  <= n_c0;
        r_ni0 <= n_ni0;
        r_nt0 <= n_nt0;

        r_c1   <= r_c0;
        r_ni1  <= r_ni0;
        r_nt1  <= r_nt0;
        r_ni2  <= r_ni0 * r_ni0;
        r_nt2  <= r_nt0 * r_nt0;
        r_nint <= r_ni0 * r_nt0;
        r_s2   <= fdr_pkg::S2_W'(31'(1 << 28) - {1'b0, w_cc});

        r_ni2x <= r_ni1;
        r_nt2x <= r_nt1;
        r_lhs  <= r_ni2 * r_s2;
        r_rhs  <= {r_nt2, 28'd0};
        r_a2   <= r_nt2 * r_c1;
        r_cc2  <= r_nint * r_c1;

        r_side3.tir <= (r_lhs >= {1'b0, r_rhs});
        r_side3.a   <= r_a2;
        r_side3.cc  <= r_cc2;
        r_side3.ni  <= r_ni2x;
        r_side3.nt  <= r_nt2x;
        r_sq3.d     <= fdr_pkg::D_W'({1'b0, r_rhs} - r_lhs);
        r_sq3.rem   <= '0;
        r_sq3.root  <= '0;
    end

    // square root chain, one root bit per cell
    logic           w_sv   [fdr_pkg::SQRT_STEPS+1];
    fdr_pkg::t_side w_side [fdr_pkg::SQRT_STEPS+1];
    fdr_pkg::t_sq   w_sq   [fdr_pkg::SQRT_STEPS+1];

    assign w_sv[0]   = r_v3;
    assign w_side[0] = r_side3;
    assign w_sq[0]   = r_sq3;

    for (genvar k = 0; k < fdr_pkg::SQRT_STEPS; k++) begin : g_sqrt
        fdr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sv[k]),
            .i_side  (w_side[k]),
            .i_sq    (w_sq[k]),
            .o_valid (w_sv[k+1]),
            .o_side  (w_side[k+1]),
            .o_sq    (w_sq[k+1])
        );
    end

    // stage 4: denominator products with the root
    fdr_pkg::t_side             w_sl;
    fdr_pkg::t_sq               w_ql;
    logic                       r_v4, r_tir4;
    logic [fdr_pkg::PROD_W-1:0] r_a4, r_c4;
    logic [fdr_pkg::RB_W-1:0]   r_b4, r_e4;

    assign w_sl = w_side[fdr_pkg::SQRT_STEPS];
    assign w_ql = w_sq[fdr_pkg::SQRT_STEPS];

    // stage 5: ratio difference magnitudes and sums
    logic                       r_v5;
    fdr_pkg::t_div              r_div5;

    function automatic fdr_pkg::t_lane lane_init(input logic [fdr_pkg::PROD_W-1:0] x,
                                                 input logic [fdr_pkg::RB_W-1:0] y);
        fdr_pkg::t_lane              l;
        logic [fdr_pkg::PROD_W-1:0]  yy;
        yy    = {1'b0, y};
        l.rem = (x >= yy) ? fdr_pkg::DREM_W'(x - yy) : fdr_pkg::DREM_W'(yy - x);
        l.den = fdr_pkg::DEN_W'(x) + fdr_pkg::DEN_W'(yy);
        l.quo = '0;
        return l;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= w_sv[fdr_pkg::SQRT_STEPS];
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tir4 <= w_sl.tir;
        r_a4   <= w_sl.a;
        r_c4   <= w_sl.cc;
        r_b4   <= w_sl.ni * w_ql.root;
        r_e4   <= w_sl.nt * w_ql.root;

        r_div5.tir <= r_tir4;
        r_div5.p   <= lane_init(r_a4, r_b4);
        r_div5.q   <= lane_init(r_c4, r_e4);
    end

    // division chain, one quotient bit per cell for both ratios
    logic          w_dv  [fdr_pkg::DIV_STEPS+1];
    fdr_pkg::t_div w_div [fdr_pkg::DIV_STEPS+1];

    assign w_dv[0]  = r_v5;
    assign w_div[0] = r_div5;

    for (genvar k = 0; k < fdr_pkg::DIV_STEPS; k++) begin : g_div
        fdr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[k]),
            .i_div   (w_div[k]),
            .o_valid (w_dv[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // stage 6: squares of both ratios
    fdr_pkg::t_div                 w_dl;
    logic                          r_v6, r_tir6;
    logic [2*fdr_pkg::QUO_W-1:0]   r_pp, r_qq;

    assign w_dl = w_div[fdr_pkg::DIV_STEPS];

    // stage 7: mean with round half up, saturate, total reflection override
    logic [2*fdr_pkg::QUO_W:0]     w_sum;
    logic [fdr_pkg::QUO_W-1:0]     w_mean;
    logic [fdr_pkg::REFL_W-1:0]    n_refl;

    always_comb begin
        w_sum  = {1'b0, r_pp} + {1'b0, r_qq} + 35'(1 << 17);
        w_mean = w_sum[2*fdr_pkg::QUO_W -: fdr_pkg::QUO_W];
        if (r_tir6 || (w_mean > {1'b0, fdr_pkg::REFL_FULL})) begin
            n_refl = fdr_pkg::REFL_FULL;
        end else begin
            n_refl = w_mean[fdr_pkg::REFL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v6    <= w_dv[fdr_pkg::DIV_STEPS];
            o_valid <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tir6             <= w_dl.tir;
        r_pp               <= w_dl.p.quo * w_dl.p.quo;
        r_qq               <= w_dl.q.quo * w_dl.q.quo;
        o_reflectance      <= n_refl;
        o_total_reflection <= r_tir6;
    end

endmodule

[bench/fresnel_dielectric_reflectance_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_test: self-checking bench for the fresnel block
// drives directed and random cosine items, the random ones in bursts, predicts reflectance in exact integer
// math per index setting, and compares every strobed result in order
// ----------------------------------------------------------------------------
class fresnel_scoreboard;
    logic [15:0] exp_refl[$];
    logic        exp_tir[$];
    logic [15:0] eta_i = 16'd8192;
    logic [15:0] eta_t = 16'd8192;
    int          errors = 0;

    static function logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function logic [63:0] ratio16(logic [63:0] x, logic [63:0] y);
        logic [63:0] dif;
        dif = (x >= y) ? x - y : y - x;
        if (x + y == 0) return 0;
        return (dif << 16) / (x + y);
    endfunction

    // note an accepted cosine and queue its expected result
    function void note_cosine(logic signed [15:0] cs_in);
        int          cs;
        logic [63:0] ni, nt, tmp, c, s2, lhs, rhs, r, p, q, refl;
        cs = cs_in;
        ni = (eta_i == 0) ? 64'd1 : 64'(eta_i);
        nt = (eta_t == 0) ? 64'd1 : 64'(eta_t);
        if (cs > 16384) cs = 16384;
        if (cs < -16384) cs = -16384;
        if (cs < 0) begin
            tmp = ni; ni = nt; nt = tmp;
            c = 64'(-cs);
        end else begin
            c = 64'(cs);
        end
        s2  = (64'd1 << 28) - c * c;
        lhs = ni * ni * s2;
        rhs = (nt * nt) << 28;
        if (lhs >= rhs) begin
            exp_refl.push_back(16'd32768);
            exp_tir.push_back(1'b1);
        end else begin
            r = int_sqrt(rhs - lhs);
            p = ratio16(nt * nt * c, ni * r);
            q = ratio16(ni * nt * c, nt * r);
            refl = (p * p + q * q + (64'd1 << 17)) >> 18;
            if (refl > 32768) refl = 32768;
            exp_refl.push_back(refl[15:0]);
            exp_tir.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [15:0] refl, logic tir);
        logic [15:0] er;
        logic        et;
        if (exp_refl.size() == 0) begin
            $error("unexpected result reflectance %0d", refl);
            errors++;
            return;
        end
        er = exp_refl.pop_front();
        et = exp_tir.pop_front();
        if (refl !== er) begin
            $error("reflectance expected %0d actual %0d", er, refl);
            errors++;
        end
        if (tir !== et) begin
            $error("total_reflection expected %0d actual %0d", et, tir);
            errors++;
        end
    endfunction
endclass

module fresnel_dielectric_reflectance_test;

    localparam int LATENCY = 55;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_cos_incident = '0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_idx = fdr_pkg::REG_ETA_I;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [15:0]        o_reflectance;
    logic               o_total_reflection;

    fresnel_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;

    fresnel_dielectric_reflectance dut (.*);

    always #5 i_clk = ~i_clk;

    // checker and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) sb.check_result(o_reflectance, o_total_reflection);
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // register write while idle
    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fdr_pkg::REG_ETA_I) sb.eta_i = val;
        else sb.eta_t = val;
    endtask

    // one item; start stays high across back-to-back items
    task automatic send_cosine(logic signed [15:0] v);
        start          <= 1'b1;
        i_cos_incident <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cosine(v);
    endtask

    // sender gaps in bursts
    task automatic maybe_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.exp_refl.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // mostly in-range cosines, sometimes out of range or extreme
    function automatic logic signed [15:0] rand_cosine();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return 16'(-16384);
            2: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    function automatic logic [15:0] rand_eta();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            default: return 16'($urandom_range(8192, 24576));
        endcase
    endfunction

    initial begin
        logic signed [15:0] directed[$];
        logic [15:0]        eta_pairs[$];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamp extremes, normal, grazing, swap, bit patterns
        directed = '{16'sh7FFF, -16'sh8000, 16'sd16384, -16'sd16384, 16'sd16385,
                     -16'sd16385, 16'sd0, 16'sd1, -16'sd1, 16'sd8192, -16'sd8192,
                     16'sh5555, -16'sh2AAB, 16'sd12000, -16'sd3000};
        // index pairs: glass-air both ways, extremes, zero registers
        eta_pairs = '{16'd8192, 16'd12288, 16'd12288, 16'd8192, 16'd0, 16'hFFFF,
                      16'hFFFF, 16'd0, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF};
        foreach (directed[k]) send_cosine(directed[k]);
        drain();
        for (int p = 0; p < eta_pairs.size(); p += 2) begin
            write_reg(fdr_pkg::REG_ETA_I, eta_pairs[p]);
            write_reg(fdr_pkg::REG_ETA_T, eta_pairs[p+1]);
            foreach (directed[k]) if (k % 2 == p % 4 / 2 || k < 8) send_cosine(directed[k]);
            drain();
        end

        // random phases with fresh index settings
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(fdr_pkg::REG_ETA_I, rand_eta());
            write_reg(fdr_pkg::REG_ETA_T, rand_eta());
            for (int n = 0; n < 100; n++) begin
                maybe_gap();
                send_cosine(rand_cosine());
            end
            drain();
        end

        if (sb.errors == 0 && sb.exp_refl.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_sqrt_cell.sv
hw/rtl/fdr_div_cell.sv
hw/rtl/fresnel_dielectric_reflectance.sv
bench/fresnel_dielectric_reflectance_test.sv
